// File: sv/tbof_pkg.sv
package tbof_pkg;

  // Default number of queue entries
  localparam int unsigned DepthDef = 64;

  // Fixed field widths
  localparam int unsigned CapW   = 24;
  localparam int unsigned SizeW  = 16;
  localparam int unsigned TimeW  = 33;
  localparam int unsigned FreeW  = 25;
  localparam int unsigned CountW = 7;

  // Stream payload layout
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 32;

  // Item kinds carried in the input tuser
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAN = 1'b1;

  // Sequencer step addresses
  typedef logic [2:0] step_t;
  localparam step_t ST_WAIT = 3'd0;
  localparam step_t ST_DISP = 3'd1;
  localparam step_t ST_ADD  = 3'd2;
  localparam step_t ST_READ = 3'd3;
  localparam step_t ST_TEST = 3'd4;
  localparam step_t ST_EMIT = 3'd5;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_LATCH,
    ACT_PUSH,
    ACT_READ,
    ACT_POP,
    ACT_EMIT
  } act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_IN,
    COND_CLEAN,
    COND_EMPTY,
    COND_LESS,
    COND_OUT_BUSY
  } cond_e;

  // One control word: action, branch condition, target if true / if false
  typedef struct packed {
    act_e  act;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  // Control store
  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    unique case (pc)
      ST_WAIT: w = '{act: ACT_LATCH, cond: COND_NO_IN,    tgt_t: ST_WAIT, tgt_f: ST_DISP};
      ST_DISP: w = '{act: ACT_NOP,   cond: COND_CLEAN,    tgt_t: ST_READ, tgt_f: ST_ADD};
      ST_ADD:  w = '{act: ACT_PUSH,  cond: COND_ALWAYS,   tgt_t: ST_EMIT, tgt_f: ST_EMIT};
      ST_READ: w = '{act: ACT_READ,  cond: COND_EMPTY,    tgt_t: ST_EMIT, tgt_f: ST_TEST};
      ST_TEST: w = '{act: ACT_POP,   cond: COND_LESS,     tgt_t: ST_READ, tgt_f: ST_EMIT};
      ST_EMIT: w = '{act: ACT_EMIT,  cond: COND_OUT_BUSY, tgt_t: ST_EMIT, tgt_f: ST_WAIT};
      default: w = '{act: ACT_NOP,   cond: COND_ALWAYS,   tgt_t: ST_WAIT, tgt_f: ST_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: sv/timestamped_buffer_occupancy_fifo_unit.sv
// Add transaction: steps from acceptance to result are accept, dispatch, push, emit.
// Clean transaction: accept, dispatch, then a read and a test per removed entry; it ends with a read
//   that finds the queue empty, or with a read and a failed test when a head entry is kept, then emit.
// One transaction in flight at a time; the next is accepted while the result waits.
// rst_ni (async, active low) empties the queue and clears capacity to zero;
//   entry memory contents are not cleared, only written entries are ever used.
module timestamped_buffer_occupancy_fifo_unit #(
  parameter int unsigned QUEUE_DEPTH = tbof_pkg::DepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config: capacity in bytes
  input  logic                          cfg_we_i,
  input  logic [tbof_pkg::CapW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] entry_bytes, [48:16] decode_time, [81:49] system_clock, [87:82] zero
  input  logic [tbof_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [0] func (0 add, 1 clean)
  input  logic                          s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [24:0] free_space (signed), [31:25] entry_count
  output logic [tbof_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [0] add_dropped
  output logic                          m_axis_tuser_o
);
  import tbof_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  step_t  pc_q, pc_d;
  uword_t uw;
  logic   cond_hit;

  // Datapath state
  logic [CapW-1:0]  cap_q;
  logic [IdxW-1:0]  head_q, tail_q;
  logic [CntW-1:0]  count_q;
  logic [FreeW-1:0] bytes_q;        // running byte total, kept modulo 2^25
  logic             drop_q;

  // Latched transaction
  logic             func_q;
  logic [SizeW-1:0] size_q;
  logic [TimeW-1:0] stamp_q;
  logic [TimeW-1:0] sys_q;

  // Entry memory and its registered read port
  logic [TimeW+SizeW-1:0] mem [QUEUE_DEPTH];
  logic [TimeW+SizeW-1:0] rd_q;
  logic [TimeW-1:0]       rd_time;
  logic [SizeW-1:0]       rd_size;

  // Output register
  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_user_q;

  logic in_fire, out_free, full, empty, less;
  logic [FreeW-1:0] free_now;

  assign uw       = ucode_rom(pc_q);
  assign rd_time  = rd_q[TimeW+SizeW-1:SizeW];
  assign rd_size  = rd_q[SizeW-1:0];
  assign full     = (count_q == FullCnt);
  assign empty    = (count_q == '0);
  assign less     = (rd_time < sys_q);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign free_now = FreeW'(cap_q) - bytes_q;

  assign s_axis_tready_o = (uw.act == ACT_LATCH);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Branch condition and next step
  always_comb begin
    unique case (uw.cond)
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_IN:    cond_hit = !in_fire;
      COND_CLEAN:    cond_hit = (func_q == FUNC_CLEAN);
      COND_EMPTY:    cond_hit = empty;
      COND_LESS:     cond_hit = less;
      COND_OUT_BUSY: cond_hit = !out_free;
      default:       cond_hit = 1'b1;
    endcase
    pc_d = cond_hit ? uw.tgt_t : uw.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= ST_WAIT;
    end else begin
      pc_q <= pc_d;
    end
  end

  // ---------------------------------------------------------------------
  // Control datapath
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      bytes_q   <= '0;
      drop_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      // new result replaces a taken one in the same cycle
      if (uw.act == ACT_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (uw.act)
        ACT_LATCH: begin
          if (in_fire) begin
            drop_q <= 1'b0;
          end
        end
        ACT_PUSH: begin
          if (full) begin
            drop_q <= 1'b1;
          end else begin
            tail_q  <= (tail_q == LastIdx) ? '0 : tail_q + 1'b1;
            count_q <= count_q + 1'b1;
            bytes_q <= bytes_q + FreeW'(size_q);
          end
        end
        ACT_POP: begin
          if (less) begin
            head_q  <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
            count_q <= count_q - 1'b1;
            bytes_q <= bytes_q - FreeW'(rd_size);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Payload registers, entry memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q  <= s_axis_tuser_i;
      size_q  <= s_axis_tdata_i[SizeW-1:0];
      stamp_q <= s_axis_tdata_i[SizeW+TimeW-1:SizeW];
      sys_q   <= s_axis_tdata_i[SizeW+2*TimeW-1:SizeW+TimeW];
    end
    if (uw.act == ACT_EMIT && out_free) begin
      m_data_q <= {CountW'(count_q), free_now};
      m_user_q <= drop_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uw.act == ACT_PUSH && !full) begin
      mem[tail_q] <= {stamp_q, size_q};
    end
    if (uw.act == ACT_READ) begin
      rd_q <= mem[head_q];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count above queue depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty || full) |-> head_q == tail_q)
    else $error("head/tail mismatch for empty or full queue");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.act == ACT_POP && less) |-> !empty)
    else $error("pop from empty queue");

  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(pc_q == ST_EMIT))
    else $error("result raised outside emit step");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pc_q <= ST_EMIT)
    else $error("sequencer left its program");

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tbof_pkg::*;

  localparam int unsigned Depth       = DepthDef;
  // Generous bound on the length of the whole run.
  localparam int unsigned MaxCycles   = 1_000_000;
  // Worst clean: one that removes the whole queue, plus a settling margin.
  localparam int unsigned DrainCycles = 4 + 2 * Depth + 16;
  localparam int unsigned HoldCycles  = 300;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CapW-1:0]     cfg_wdata_i;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                m_axis_tuser_o;

  // Receiver and sender knobs, owned by the main sequence.
  bit               tx_idle_en = 1'b1;
  bit               rx_idle_en = 1'b1;
  bit               hold_req   = 1'b0;
  logic [TimeW-1:0] now_t      = '0;    // running time base for well-formed traffic
  int unsigned      cycle_count = 0;

  // One occupancy report, fields as they come out on the result stream.
  typedef struct packed {
    logic [FreeW-1:0]  free_space;
    logic [CountW-1:0] entry_count;
    logic              add_dropped;
  } occ_report_t;

  // Buffer occupancy predictor plus the queue of reports still owed by the DUT.
  class buffer_occupancy_model;
    logic [CapW-1:0]  capacity;
    logic [SizeW-1:0] size_q[$];
    logic [TimeW-1:0] time_q[$];
    logic [21:0]      held_bytes;
    occ_report_t      expected_reports[$];
    int               errors;

    function new();
      capacity   = '0;
      held_bytes = '0;
      errors     = 0;
    endfunction

    function void set_capacity(logic [CapW-1:0] value);
      capacity = value;
    endfunction

    // Apply one accepted transaction and queue the report it must produce.
    function void accept_item(logic kind, logic [SizeW-1:0] nbytes,
                              logic [TimeW-1:0] dts, logic [TimeW-1:0] sclk);
      occ_report_t rep;
      rep.add_dropped = 1'b0;
      if (kind == FUNC_ADD) begin
        if (size_q.size() >= Depth) begin
          rep.add_dropped = 1'b1;
        end else begin
          size_q.push_back(nbytes);
          time_q.push_back(dts);
          held_bytes += nbytes;
        end
      end else begin
        // strict unsigned compare, head first, stop at the first survivor
        while (size_q.size() > 0 && time_q[0] < sclk) begin
          held_bytes -= size_q[0];
          void'(size_q.pop_front());
          void'(time_q.pop_front());
        end
      end
      rep.free_space  = FreeW'(capacity) - FreeW'(held_bytes);
      rep.entry_count = CountW'(size_q.size());
      expected_reports.push_back(rep);
    endfunction

    function void check_report(logic [OutDataW-1:0] data, logic dropped);
      occ_report_t       exp;
      logic [FreeW-1:0]  got_free;
      logic [CountW-1:0] got_count;
      got_free  = data[FreeW-1:0];
      got_count = data[FreeW +: CountW];
      if (expected_reports.size() == 0) begin
        $display("%0t unexpected report: expected none, actual tdata %h tuser %b",
                 $time, data, dropped);
        errors++;
        return;
      end
      exp = expected_reports.pop_front();
      if (got_free !== exp.free_space) begin
        $display("%0t free_space mismatch: expected %0d actual %0d",
                 $time, $signed(exp.free_space), $signed(got_free));
        errors++;
      end
      if (got_count !== exp.entry_count) begin
        $display("%0t entry_count mismatch: expected %0d actual %0d",
                 $time, exp.entry_count, got_count);
        errors++;
      end
      if (dropped !== exp.add_dropped) begin
        $display("%0t add_dropped mismatch: expected %b actual %b",
                 $time, exp.add_dropped, dropped);
        errors++;
      end
    endfunction
  endclass

  buffer_occupancy_model occ_model;

  timestamped_buffer_occupancy_fifo_unit #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result monitor. Sampled at the rising edge, before the DUT's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      occ_model.check_report(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Result receiver. Ready changes only at the falling edge, one assignment per edge.
  // A hold request parks ready low for a long stretch counted here, so the DUT backs
  // up and drops its input ready while the sender keeps offering.
  initial begin
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req        = 1'b0;
        m_axis_tready_i = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready_i = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        m_axis_tready_i = 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  function automatic logic [TimeW-1:0] rand_time();
    return {1'($urandom_range(0, 1)), 32'($urandom)};
  endfunction

  // Offer one transaction and hold it until the DUT takes it.
  task automatic send_item(logic kind, logic [SizeW-1:0] nbytes,
                           logic [TimeW-1:0] dts, logic [TimeW-1:0] sclk);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = kind;
    s_axis_tdata_i  = {6'd0, sclk, dts, nbytes};
    do @(posedge clk_i); while (!s_axis_tready_o);
    occ_model.accept_item(kind, nbytes, dts, sclk);
  endtask

  task automatic pause_sender(int unsigned cycles);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  // Sender goes quiet until every owed report is back, then settles.
  task automatic drain_results(int unsigned settle);
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (occ_model.expected_reports.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Capacity is only written with the DUT idle.
  task automatic write_capacity(logic [CapW-1:0] value);
    drain_results(8);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    occ_model.set_capacity(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly well-formed traffic around a drifting time base: adds stamped a little
  // ahead of it, cleans with a clock near it or at or just past the head's stamp.
  // About one in twelve is pure noise with every field random.
  task automatic random_item(int unsigned add_pct, int unsigned drift);
    logic             kind;
    logic [SizeW-1:0] nbytes;
    logic [TimeW-1:0] dts;
    logic [TimeW-1:0] sclk;
    bit               noise;
    noise  = ($urandom_range(0, 99) < 8);
    kind   = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_CLEAN;
    nbytes = SizeW'($urandom);
    if ($urandom_range(0, 3) == 0) nbytes = SizeW'($urandom_range(0, 255));
    dts    = rand_time();
    sclk   = rand_time();
    if (!noise) begin
      if (kind == FUNC_ADD) begin
        dts   = now_t + TimeW'($urandom_range(0, 2000));
        now_t = now_t + TimeW'($urandom_range(0, drift));
      end else begin
        if (occ_model.time_q.size() > 0 && $urandom_range(0, 4) == 0) begin
          sclk = occ_model.time_q[0] + TimeW'($urandom_range(0, 1));
        end else begin
          sclk = now_t + TimeW'($urandom_range(0, 1500));
        end
        now_t = now_t + TimeW'($urandom_range(0, 4 * drift));
      end
    end
    send_item(kind, nbytes, dts, sclk);
  endtask

  task automatic run_phase(logic [CapW-1:0] cap, int unsigned add_pct,
                           int unsigned drift, int unsigned count, int hold_at);
    write_capacity(cap);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      random_item(add_pct, drift);
      if (tx_idle_en && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 16));
    end
  endtask

  initial begin
    occ_model       = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = FUNC_ADD;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, capacity still at its reset value of zero.
    send_item(FUNC_CLEAN, '1, '1, '1);                 // clean on empty queue
    send_item(FUNC_ADD, 16'hFFFF, 33'd0, '1);          // largest packet, earliest stamp
    send_item(FUNC_ADD, 16'h0000, 33'd1000, '0);       // empty packet
    send_item(FUNC_ADD, 16'h0001, 33'h1_FFFF_FFFE, '0);
    send_item(FUNC_CLEAN, '0, '0, 33'd0);              // clock zero removes nothing
    send_item(FUNC_CLEAN, '1, '1, 33'd1000);           // equal stamp survives
    send_item(FUNC_CLEAN, '0, '0, 33'd1001);
    send_item(FUNC_CLEAN, '0, '0, 33'h1_FFFF_FFFF);    // top clock empties queue
    send_item(FUNC_ADD, 16'hFFFF, 33'h1_0000_0000, '1);
    send_item(FUNC_ADD, 16'h8000, 33'd10, '0);
    send_item(FUNC_CLEAN, '0, '0, 33'h1_0000_0000);    // head equal, blocks younger one
    send_item(FUNC_CLEAN, '0, '0, 33'h1_0000_0001);    // both leave
    write_capacity('1);
    send_item(FUNC_ADD, 16'hFFFF, 33'd5, '0);
    send_item(FUNC_CLEAN, '0, '0, 33'd6);

    // Random phases, each behind an idle capacity write.
    now_t = rand_time() >> 1;
    run_phase('1, 55, 200, 300, -1);
    // heavy adds: queue fills, adds drop, zero capacity goes negative; long hold
    run_phase('0, 90, 20, 300, 100);
    run_phase(CapW'($urandom), 30, 400, 250, -1);
    // time base near the top so stamps and clocks wrap
    now_t = '1 - TimeW'(20000);
    run_phase(CapW'(Depth * 65535), 60, 200, 300, -1);
    run_phase(CapW'($urandom_range(0, 5000)), 85, 10, 300, -1);
    // closing stretch at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_phase(CapW'($urandom), 55, 150, 450, -1);

    drain_results(DrainCycles);
    if (occ_model.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
